[rtl/core/ffr_pkg.sv]
// ----------------------------------------------------------------------------
// ffr_pkg
// Shared types, constants and MD5 helper functions for the framed receiver.
// ----------------------------------------------------------------------------
package ffr_pkg;

   // Item kinds on the request channel.
   localparam logic CMD_BYTE = 1'b0;
   localparam logic CMD_TICK = 1'b1;

   // Configuration register indexes.
   localparam logic REG_PREAMBLE   = 1'b0;
   localparam logic REG_IDLE_LIMIT = 1'b1;

   localparam logic [15:0] IDLE_LIMIT_RESET = 16'd1000;
   localparam int          BLOCK_BYTES      = 64;
   localparam int          DIGEST_BYTES     = 16;

   typedef enum logic [1:0] {
      PH_HUNT,
      PH_LENGTH,
      PH_PAYLOAD,
      PH_DIGEST
   } ffr_phase_type;

   typedef enum logic [1:0] {
      EV_PAYLOAD,
      EV_ACCEPT,
      EV_REJECT,
      EV_ABORT
   } ffr_event_type;

   typedef enum logic [1:0] {
      MD_IDLE,
      MD_PAD,
      MD_ROUND,
      MD_ADD
   } ffr_md5_state_type;

   // One queued input transaction.
   typedef struct packed {
      logic       cmd;
      logic [7:0] data;
   } ffr_item_type;

   // Commands from the frame parser to the hash engine.
   typedef struct packed {
      logic        init;
      logic        wr;
      logic [5:0]  wr_addr;
      logic [7:0]  wr_data;
      logic        compress;
      logic        finish;
      logic [31:0] length;
   } ffr_md5_cmd_type;

   localparam logic [31:0] MD5_IV0 = 32'h67452301;
   localparam logic [31:0] MD5_IV1 = 32'hefcdab89;
   localparam logic [31:0] MD5_IV2 = 32'h98badcfe;
   localparam logic [31:0] MD5_IV3 = 32'h10325476;

   localparam logic [31:0] MD5_K [64] = '{
      32'hd76aa478, 32'he8c7b756, 32'h242070db, 32'hc1bdceee,
      32'hf57c0faf, 32'h4787c62a, 32'ha8304613, 32'hfd469501,
      32'h698098d8, 32'h8b44f7af, 32'hffff5bb1, 32'h895cd7be,
      32'h6b901122, 32'hfd987193, 32'ha679438e, 32'h49b40821,
      32'hf61e2562, 32'hc040b340, 32'h265e5a51, 32'he9b6c7aa,
      32'hd62f105d, 32'h02441453, 32'hd8a1e681, 32'he7d3fbc8,
      32'h21e1cde6, 32'hc33707d6, 32'hf4d50d87, 32'h455a14ed,
      32'ha9e3e905, 32'hfcefa3f8, 32'h676f02d9, 32'h8d2a4c8a,
      32'hfffa3942, 32'h8771f681, 32'h6d9d6122, 32'hfde5380c,
      32'ha4beea44, 32'h4bdecfa9, 32'hf6bb4b60, 32'hbebfbc70,
      32'h289b7ec6, 32'heaa127fa, 32'hd4ef3085, 32'h04881d05,
      32'hd9d4d039, 32'he6db99e5, 32'h1fa27cf8, 32'hc4ac5665,
      32'hf4292244, 32'h432aff97, 32'hab9423a7, 32'hfc93a039,
      32'h655b59c3, 32'h8f0ccc92, 32'hffeff47d, 32'h85845dd1,
      32'h6fa87e4f, 32'hfe2ce6e0, 32'ha3014314, 32'h4e0811a1,
      32'hf7537e82, 32'hbd3af235, 32'h2ad7d2bb, 32'heb86d391
   };

   localparam logic [4:0] MD5_S [16] = '{
      5'd7, 5'd12, 5'd17, 5'd22, 5'd5, 5'd9, 5'd14, 5'd20,
      5'd4, 5'd11, 5'd16, 5'd23, 5'd6, 5'd10, 5'd15, 5'd21
   };

   // Message word index used by a given round.
   function automatic logic [3:0] md5_g(input logic [5:0] rnd);
      logic [3:0] i;
      i = rnd[3:0];
      case (rnd[5:4])
         2'd0:    md5_g = i;
         2'd1:    md5_g = 4'((i << 2) + i + 4'd1);
         2'd2:    md5_g = 4'((i << 1) + i + 4'd5);
         default: md5_g = 4'((i << 3) - i);
      endcase
   endfunction

   // Round function of the four round groups.
   function automatic logic [31:0] md5_f(input logic [5:0] rnd, input logic [31:0] b,
                                         input logic [31:0] c, input logic [31:0] d);
      case (rnd[5:4])
         2'd0:    md5_f = (b & c) | (~b & d);
         2'd1:    md5_f = (d & b) | (~d & c);
         2'd2:    md5_f = b ^ c ^ d;
         default: md5_f = c ^ (b | ~d);
      endcase
   endfunction

   // Rotate left by a nonzero amount.
   function automatic logic [31:0] md5_rotl(input logic [31:0] x, input logic [4:0] s);
      logic [63:0] t;
      t = {x, x} << s;
      md5_rotl = t[63:32];
   endfunction

endpackage

[rtl/core/ffr_front.sv]
// ----------------------------------------------------------------------------
// ffr_front
// Input queue that takes request transactions and holds them for the parser.
// ----------------------------------------------------------------------------
module ffr_front #(
   parameter int DEPTH = 4
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 push,
   output logic                 full,
   input  ffr_pkg::ffr_item_type item_in,
   output logic                 item_valid,
   input  logic                 item_pop,
   output ffr_pkg::ffr_item_type item_out
);

   localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CW = $clog2(DEPTH + 1);

   ffr_pkg::ffr_item_type slot_ff [DEPTH];
   logic [PW-1:0] wr_ptr_ff, wr_ptr_in;
   logic [PW-1:0] rd_ptr_ff, rd_ptr_in;
   logic [CW-1:0] count_ff, count_in;
   logic          do_push, do_pop;

   assign full       = (count_ff == CW'(DEPTH));
   assign item_valid = (count_ff != '0);
   assign item_out   = slot_ff[rd_ptr_ff];
   assign do_push    = push && !full;
   assign do_pop     = item_pop && item_valid;

   // Pointer and fill count update.
   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (do_push) begin
         wr_ptr_in = (wr_ptr_ff == PW'(DEPTH - 1)) ? '0 : PW'(wr_ptr_ff + 1'b1);
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == PW'(DEPTH - 1)) ? '0 : PW'(rd_ptr_ff + 1'b1);
      end
      if (do_push && !do_pop) begin
         count_in = CW'(count_ff + 1'b1);
      end else if (do_pop && !do_push) begin
         count_in = CW'(count_ff - 1'b1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   // Storage for queued transactions.
   always_ff @(posedge clock) begin
      if (do_push) begin
         slot_ff[wr_ptr_ff] <= item_in;
      end
   end

endmodule

[rtl/core/ffr_md5.sv]
// ----------------------------------------------------------------------------
// ffr_md5
// MD5 engine: block buffer, padding writer and one round per cycle.
// ----------------------------------------------------------------------------
module ffr_md5 (
   input  logic                    clock,
   input  logic                    reset,
   input  ffr_pkg::ffr_md5_cmd_type cmd,
   output logic                    busy,
   output logic [127:0]            digest
);

   ffr_pkg::ffr_md5_state_type state_ff, state_in;

   logic [3:0][7:0] block_mem [16];
   logic [31:0] rd_ff, km_ff;
   logic [31:0] a_ff, b_ff, c_ff, d_ff;
   logic [31:0] dig_ff [4];
   logic [6:0]  step_ff;
   logic [5:0]  pad_addr_ff;
   logic        first_ff, lenblk_ff, fin_ff;
   logic [31:0] len_ff;

   logic        wr_en;
   logic [5:0]  wr_addr;
   logic [7:0]  wr_data;
   logic [63:0] len_bits;
   logic [5:0]  rnd;
   logic [5:0]  km_idx;
   logic [3:0]  rd_addr;
   logic [31:0] round_sum;

   assign busy     = (state_ff != ffr_pkg::MD_IDLE);
   assign digest   = {dig_ff[3], dig_ff[2], dig_ff[1], dig_ff[0]};
   assign len_bits = {29'd0, len_ff, 3'd0};
   assign rnd      = 6'(step_ff - 7'd2);
   assign km_idx   = 6'(step_ff - 7'd1);
   assign rd_addr  = ffr_pkg::md5_g(step_ff[5:0]);
   assign round_sum = a_ff + ffr_pkg::md5_f(rnd, b_ff, c_ff, d_ff) + km_ff;

   // Next state.
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ffr_pkg::MD_IDLE: begin
            if (cmd.finish) begin
               state_in = ffr_pkg::MD_PAD;
            end else if (cmd.compress) begin
               state_in = ffr_pkg::MD_ROUND;
            end
         end
         ffr_pkg::MD_PAD: begin
            if (pad_addr_ff == 6'd63) begin
               state_in = ffr_pkg::MD_ROUND;
            end
         end
         ffr_pkg::MD_ROUND: begin
            if (step_ff == 7'd65) begin
               state_in = ffr_pkg::MD_ADD;
            end
         end
         ffr_pkg::MD_ADD: begin
            state_in = (fin_ff && !lenblk_ff) ? ffr_pkg::MD_PAD : ffr_pkg::MD_IDLE;
         end
         default: state_in = ffr_pkg::MD_IDLE;
      endcase
   end

   // Buffer write source: parser bytes when idle, padding bytes in the pad state.
   always_comb begin
      wr_en   = 1'b0;
      wr_addr = cmd.wr_addr;
      wr_data = cmd.wr_data;
      if (state_ff == ffr_pkg::MD_IDLE) begin
         wr_en = cmd.wr;
      end else if (state_ff == ffr_pkg::MD_PAD) begin
         wr_en   = 1'b1;
         wr_addr = pad_addr_ff;
         if (first_ff) begin
            wr_data = 8'h80;
         end else if (lenblk_ff && (pad_addr_ff >= 6'd56)) begin
            wr_data = len_bits[8*pad_addr_ff[2:0] +: 8];
         end else begin
            wr_data = 8'h00;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ffr_pkg::MD_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   // Block buffer, one byte lane written and one word read per cycle.
   always_ff @(posedge clock) begin
      if (wr_en) begin
         block_mem[wr_addr[5:2]][wr_addr[1:0]] <= wr_data;
      end
      rd_ff <= block_mem[rd_addr];
   end

   // Digest words.
   always_ff @(posedge clock) begin
      if (reset) begin
         dig_ff[0] <= ffr_pkg::MD5_IV0;
         dig_ff[1] <= ffr_pkg::MD5_IV1;
         dig_ff[2] <= ffr_pkg::MD5_IV2;
         dig_ff[3] <= ffr_pkg::MD5_IV3;
      end else if (state_ff == ffr_pkg::MD_IDLE && cmd.init) begin
         dig_ff[0] <= ffr_pkg::MD5_IV0;
         dig_ff[1] <= ffr_pkg::MD5_IV1;
         dig_ff[2] <= ffr_pkg::MD5_IV2;
         dig_ff[3] <= ffr_pkg::MD5_IV3;
      end else if (state_ff == ffr_pkg::MD_ADD) begin
         dig_ff[0] <= dig_ff[0] + a_ff;
         dig_ff[1] <= dig_ff[1] + b_ff;
         dig_ff[2] <= dig_ff[2] + c_ff;
         dig_ff[3] <= dig_ff[3] + d_ff;
      end
   end

   // Padding control, round counter and working variables.
   always_ff @(posedge clock) begin
      if (reset) begin
         fin_ff      <= 1'b0;
         first_ff    <= 1'b0;
         lenblk_ff   <= 1'b0;
         step_ff     <= '0;
         pad_addr_ff <= '0;
      end else begin
         case (state_ff)
            ffr_pkg::MD_IDLE: begin
               step_ff <= '0;
               if (cmd.finish) begin
                  fin_ff      <= 1'b1;
                  first_ff    <= 1'b1;
                  lenblk_ff   <= (cmd.length[5:0] < 6'd56);
                  pad_addr_ff <= cmd.length[5:0];
               end else if (cmd.compress) begin
                  fin_ff <= 1'b0;
               end
            end
            ffr_pkg::MD_PAD: begin
               first_ff    <= 1'b0;
               pad_addr_ff <= 6'(pad_addr_ff + 1'b1);
               step_ff     <= '0;
            end
            ffr_pkg::MD_ROUND: begin
               step_ff <= 7'(step_ff + 1'b1);
            end
            ffr_pkg::MD_ADD: begin
               if (fin_ff && !lenblk_ff) begin
                  lenblk_ff   <= 1'b1;
                  first_ff    <= 1'b0;
                  pad_addr_ff <= '0;
               end else begin
                  fin_ff <= 1'b0;
               end
            end
            default: step_ff <= '0;
         endcase
      end
   end

   // Length latch and round datapath.
   always_ff @(posedge clock) begin
      if (state_ff == ffr_pkg::MD_IDLE && cmd.finish) begin
         len_ff <= cmd.length;
      end
      km_ff <= rd_ff + ffr_pkg::MD5_K[km_idx];
      if (state_in == ffr_pkg::MD_ROUND && state_ff != ffr_pkg::MD_ROUND) begin
         a_ff <= dig_ff[0];
         b_ff <= dig_ff[1];
         c_ff <= dig_ff[2];
         d_ff <= dig_ff[3];
      end else if (state_ff == ffr_pkg::MD_ROUND && step_ff >= 7'd2) begin
         a_ff <= d_ff;
         d_ff <= c_ff;
         c_ff <= b_ff;
         b_ff <= b_ff + ffr_pkg::md5_rotl(round_sum,
                                          ffr_pkg::MD5_S[{rnd[5:4], rnd[1:0]}]);
      end
   end

endmodule

[rtl/core/ffr_back.sv]
// ----------------------------------------------------------------------------
// ffr_back
// Frame parser: preamble hunt, length, payload and digest check, result slot.
// ----------------------------------------------------------------------------
module ffr_back (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     item_valid,
   input  ffr_pkg::ffr_item_type     item,
   output logic                     item_pop,
   input  logic                     csr_we,
   input  logic                     csr_index,
   input  logic [31:0]              csr_wdata,
   output ffr_pkg::ffr_md5_cmd_type  md5_cmd,
   input  logic                     md5_busy,
   input  logic [127:0]             digest,
   output logic                     rsp_empty,
   input  logic                     rsp_pop,
   output logic [1:0]               rsp_event_kind,
   output logic [7:0]               rsp_payload_byte,
   output logic                     rsp_payload_last,
   output logic [15:0]              rsp_frames_accepted,
   output logic [31:0]              rsp_frame_length
);

   ffr_pkg::ffr_phase_type phase_ff, phase_in;

   logic [31:0] preamble_ff;
   logic [15:0] limit_ff;
   logic [31:0] win_ff, win_in;
   logic [31:0] alen_ff, alen_in;
   logic [31:0] fc_ff, fc_in;
   logic [15:0] idle_ff, idle_in;
   logic [15:0] acc_ff, acc_in;
   logic        mis_ff, mis_in;
   logic        pend_ff, pend_in;

   logic        out_valid_ff, out_valid_in;
   logic [1:0]  ev_ff, ev_in;
   logic [7:0]  byte_ff, byte_in;
   logic        last_ff, last_in;
   logic [15:0] cnt_ff;
   logic [31:0] flen_ff;

   logic        out_free, go, is_tick;
   logic [15:0] idle_inc;
   logic [31:0] fc_inc;
   logic        abort, hunt_hit, len_done, pay_last, blk_full, dig_done, byte_bad;

   // Shared decode of the transaction at the head of the queue.
   assign out_free = !out_valid_ff || rsp_pop;
   assign go       = item_valid && !md5_busy && !pend_ff && out_free;
   assign item_pop = go;
   assign is_tick  = (item.cmd == ffr_pkg::CMD_TICK);
   assign idle_inc = (idle_ff == 16'hFFFF) ? idle_ff : 16'(idle_ff + 1'b1);
   assign fc_inc   = fc_ff + 32'd1;
   assign abort    = is_tick && (phase_ff != ffr_pkg::PH_HUNT) && (idle_inc >= limit_ff);
   assign hunt_hit = (fc_ff >= 32'd3) && ({win_ff[23:0], item.data} == preamble_ff);
   assign len_done = (fc_ff == 32'd3);
   assign pay_last = (fc_inc == alen_ff);
   assign blk_full = (fc_inc[5:0] == 6'd0);
   assign dig_done = (fc_ff == 32'(ffr_pkg::DIGEST_BYTES - 1));
   assign byte_bad = (digest[8*fc_ff[3:0] +: 8] != item.data);

   // Next phase.
   always_comb begin
      phase_in = phase_ff;
      if (go) begin
         if (is_tick) begin
            if (abort) begin
               phase_in = ffr_pkg::PH_HUNT;
            end
         end else begin
            case (phase_ff)
               ffr_pkg::PH_HUNT: begin
                  if (hunt_hit) begin
                     phase_in = ffr_pkg::PH_LENGTH;
                  end
               end
               ffr_pkg::PH_LENGTH: begin
                  if (len_done) begin
                     phase_in = ({alen_ff[23:0], item.data} == 32'd0) ?
                                ffr_pkg::PH_DIGEST : ffr_pkg::PH_PAYLOAD;
                  end
               end
               ffr_pkg::PH_PAYLOAD: begin
                  if (pay_last) begin
                     phase_in = ffr_pkg::PH_DIGEST;
                  end
               end
               ffr_pkg::PH_DIGEST: begin
                  if (dig_done) begin
                     phase_in = ffr_pkg::PH_HUNT;
                  end
               end
               default: phase_in = ffr_pkg::PH_HUNT;
            endcase
         end
      end
   end

   // Frame registers, engine commands and result slot.
   always_comb begin
      win_in       = win_ff;
      alen_in      = alen_ff;
      fc_in        = fc_ff;
      idle_in      = idle_ff;
      acc_in       = acc_ff;
      mis_in       = mis_ff;
      pend_in      = pend_ff;
      out_valid_in = out_valid_ff && !rsp_pop;
      ev_in        = ffr_pkg::EV_PAYLOAD;
      byte_in      = 8'd0;
      last_in      = 1'b0;
      md5_cmd      = '0;
      md5_cmd.wr_addr = fc_ff[5:0];
      md5_cmd.wr_data = item.data;
      md5_cmd.length  = alen_ff;
      if (pend_ff && !md5_busy) begin
         md5_cmd.finish = 1'b1;
         pend_in        = 1'b0;
      end
      if (go) begin
         if (is_tick) begin
            if (phase_ff != ffr_pkg::PH_HUNT) begin
               idle_in = idle_inc;
            end
            if (abort) begin
               win_in       = '0;
               fc_in        = '0;
               idle_in      = '0;
               out_valid_in = 1'b1;
               ev_in        = ffr_pkg::EV_ABORT;
            end
         end else begin
            idle_in = '0;
            case (phase_ff)
               ffr_pkg::PH_HUNT: begin
                  win_in = {win_ff[23:0], item.data};
                  if (fc_ff < 32'd4) begin
                     fc_in = fc_inc;
                  end
                  if (hunt_hit) begin
                     fc_in   = '0;
                     alen_in = '0;
                  end
               end
               ffr_pkg::PH_LENGTH: begin
                  alen_in = {alen_ff[23:0], item.data};
                  fc_in   = fc_inc;
                  if (len_done) begin
                     fc_in        = '0;
                     md5_cmd.init = 1'b1;
                     if (alen_in == 32'd0) begin
                        md5_cmd.finish = 1'b1;
                        md5_cmd.length = 32'd0;
                        mis_in         = 1'b0;
                     end
                  end
               end
               ffr_pkg::PH_PAYLOAD: begin
                  md5_cmd.wr   = 1'b1;
                  fc_in        = fc_inc;
                  out_valid_in = 1'b1;
                  ev_in        = ffr_pkg::EV_PAYLOAD;
                  byte_in      = item.data;
                  last_in      = pay_last;
                  if (blk_full) begin
                     md5_cmd.compress = 1'b1;
                  end
                  if (pay_last) begin
                     fc_in  = '0;
                     mis_in = 1'b0;
                     if (blk_full) begin
                        pend_in = 1'b1;
                     end else begin
                        md5_cmd.finish = 1'b1;
                     end
                  end
               end
               ffr_pkg::PH_DIGEST: begin
                  fc_in  = fc_inc;
                  mis_in = mis_ff || byte_bad;
                  if (dig_done) begin
                     out_valid_in = 1'b1;
                     ev_in        = mis_in ? ffr_pkg::EV_REJECT : ffr_pkg::EV_ACCEPT;
                     if (!mis_in) begin
                        acc_in = 16'(acc_ff + 1'b1);
                     end
                     win_in  = '0;
                     fc_in   = '0;
                     idle_in = '0;
                  end
               end
               default: fc_in = '0;
            endcase
         end
      end
   end

   // Control registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff     <= ffr_pkg::PH_HUNT;
         preamble_ff  <= '0;
         limit_ff     <= ffr_pkg::IDLE_LIMIT_RESET;
         win_ff       <= '0;
         alen_ff      <= '0;
         fc_ff        <= '0;
         idle_ff      <= '0;
         acc_ff       <= '0;
         mis_ff       <= 1'b0;
         pend_ff      <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         phase_ff     <= phase_in;
         win_ff       <= win_in;
         alen_ff      <= alen_in;
         fc_ff        <= fc_in;
         idle_ff      <= idle_in;
         acc_ff       <= acc_in;
         mis_ff       <= mis_in;
         pend_ff      <= pend_in;
         out_valid_ff <= out_valid_in;
         if (csr_we && csr_index == ffr_pkg::REG_PREAMBLE) begin
            preamble_ff <= csr_wdata;
         end
         if (csr_we && csr_index == ffr_pkg::REG_IDLE_LIMIT) begin
            limit_ff <= csr_wdata[15:0];
         end
      end
   end

   // Result payload, loaded when a new result is produced.
   always_ff @(posedge clock) begin
      if (go && out_valid_in && !(out_valid_ff && !rsp_pop)) begin
         ev_ff   <= ev_in;
         byte_ff <= byte_in;
         last_ff <= last_in;
         cnt_ff  <= acc_in;
         flen_ff <= alen_in;
      end
   end

   assign rsp_empty           = !out_valid_ff;
   assign rsp_event_kind      = ev_ff;
   assign rsp_payload_byte    = byte_ff;
   assign rsp_payload_last    = last_ff;
   assign rsp_frames_accepted = cnt_ff;
   assign rsp_frame_length    = flen_ff;

   // The engine is only commanded while it is idle.
   assert property (@(posedge clock) disable iff (reset)
      md5_busy |-> !(md5_cmd.wr || md5_cmd.init || md5_cmd.compress || md5_cmd.finish))
      else $error("hash engine commanded while busy");

   // A payload phase always has a nonzero announced length.
   assert property (@(posedge clock) disable iff (reset)
      (phase_ff == ffr_pkg::PH_PAYLOAD) |-> (alen_ff != 32'd0))
      else $error("payload phase with zero length");

   // An accepted verdict bumps the frame counter by one.
   assert property (@(posedge clock) disable iff (reset)
      (go && out_valid_in && ev_in == ffr_pkg::EV_ACCEPT) |=>
      (acc_ff == 16'($past(acc_ff) + 1'b1)))
      else $error("frame counter not advanced on accept");

   // Transactions leave the queue only when the result slot can take a result.
   assert property (@(posedge clock) disable iff (reset)
      item_pop |-> (out_free && !md5_busy))
      else $error("transaction consumed while stalled");

endmodule

[rtl/core/framed_file_receiver_md5_check_unit.sv]
// ----------------------------------------------------------------------------
// framed_file_receiver_md5_check_unit
// Length-prefixed frame receiver that checks each payload against its MD5.
// ----------------------------------------------------------------------------
// Header bytes, idle ticks, digest bytes and payload bytes that do not close
// a 64-byte block are taken one per cycle while the hash engine is idle and
// the output slot can take a result: each is parsed at the head of the input
// queue, and its result is registered in the output slot. A payload byte
// that completes a 64-byte block holds the parser for one compression (one
// MD5 round per cycle plus buffer read and final add). The last payload byte
// of a frame starts padding, one buffer byte per cycle from the end of the
// data to the end of the block, followed by one or two compressions; the
// digest bytes of that frame wait until this is done.
// Results queue in a one-entry output slot, and up to QUEUE_DEPTH requests
// are taken while the parser is stalled.
module framed_file_receiver_md5_check_unit #(
   parameter int QUEUE_DEPTH = 4
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_push,
   output logic        req_full,
   input  logic        req_cmd,
   input  logic [7:0]  req_rx_byte,
   output logic        rsp_empty,
   input  logic        rsp_pop,
   output logic [1:0]  rsp_event_kind,
   output logic [7:0]  rsp_payload_byte,
   output logic        rsp_payload_last,
   output logic [15:0] rsp_frames_accepted,
   output logic [31:0] rsp_frame_length,
   input  logic        csr_we,
   input  logic        csr_index,
   input  logic [31:0] csr_wdata
);

   ffr_pkg::ffr_item_type    in_item, head_item;
   ffr_pkg::ffr_md5_cmd_type md5_cmd;
   logic                     head_valid, head_pop, md5_busy;
   logic [127:0]             digest;

   assign in_item.cmd  = req_cmd;
   assign in_item.data = req_rx_byte;

   // Input queue.
   ffr_front #(
      .DEPTH(QUEUE_DEPTH)
   ) u_front (
      .clock      (clock),
      .reset      (reset),
      .push       (req_push),
      .full       (req_full),
      .item_in    (in_item),
      .item_valid (head_valid),
      .item_pop   (head_pop),
      .item_out   (head_item)
   );

   // Frame parser and result slot.
   ffr_back u_back (
      .clock               (clock),
      .reset               (reset),
      .item_valid          (head_valid),
      .item                (head_item),
      .item_pop            (head_pop),
      .csr_we              (csr_we),
      .csr_index           (csr_index),
      .csr_wdata           (csr_wdata),
      .md5_cmd             (md5_cmd),
      .md5_busy            (md5_busy),
      .digest              (digest),
      .rsp_empty           (rsp_empty),
      .rsp_pop             (rsp_pop),
      .rsp_event_kind      (rsp_event_kind),
      .rsp_payload_byte    (rsp_payload_byte),
      .rsp_payload_last    (rsp_payload_last),
      .rsp_frames_accepted (rsp_frames_accepted),
      .rsp_frame_length    (rsp_frame_length)
   );

   // Hash engine.
   ffr_md5 u_md5 (
      .clock  (clock),
      .reset  (reset),
      .cmd    (md5_cmd),
      .busy   (md5_busy),
      .digest (digest)
   );

endmodule
